// ----- src/hst_pkg.sv -----
// Package for the handle slot table: sizes, operation and status codes,
// controller state type, command struct and bitmap search functions.
// No dependencies.
package hst_pkg;

  localparam int SLOTS       = 64;
  localparam int ENTRY_WIDTH = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int IDX_W       = 6;
  localparam int DATA_W      = 64;
  localparam int LIMIT_W     = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_RETRIEVE = 2'd2,
    MODE_NOP      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } hst_cmd_t;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = SLOT_W'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [SLOT_W-1:0] highest_set(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (vec[i]) begin
        pos = SLOT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- src/handle_slot_table_core.sv -----
// Top level of the handle slot table: joins controller and datapath.
// Depends on hst_pkg, hst_ctrl, hst_dpath.
//
// Usage:
//   Input channel in_valid/in_ready carries mode, slot_index and entry_data.
//   Output channel out_valid/out_ready carries status, assigned_slot,
//   read_data, found, table_empty and highest_used, one result per item.
//   cfg_wr_en/cfg_wr_data write the slot limit; write only while idle.
// Sequence:
//   An accepted item passes through execute (bitmap search and update,
//   store write or read) and then finish (highest-used search, result
//   load); the result is registered at the end of finish. A new item is
//   taken in the finish cycle, as the last result loads, not during execute.
// Reset:
//   rst clears the used bitmap and sets the slot limit to 64. The store is
//   not cleared; entries are read only after they are written.
// Stall:
//   While a result waits unaccepted the next item may still be executed;
//   it then holds in finish and in_ready stays low until out_ready frees
//   the output register.
module handle_slot_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [hst_pkg::IDX_W-1:0]   slot_index,
  input  logic [hst_pkg::DATA_W-1:0]  entry_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [hst_pkg::IDX_W-1:0]   assigned_slot,
  output logic [hst_pkg::DATA_W-1:0]  read_data,
  output logic                        found,
  output logic                        table_empty,
  output logic [hst_pkg::IDX_W-1:0]   highest_used,
  input  logic                        cfg_wr_en,
  input  logic [hst_pkg::LIMIT_W-1:0] cfg_wr_data
);

  hst_pkg::hst_cmd_t cmd;

  hst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  hst_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mode         (mode),
    .slot_index   (slot_index),
    .entry_data   (entry_data),
    .status       (status),
    .assigned_slot(assigned_slot),
    .read_data    (read_data),
    .found        (found),
    .table_empty  (table_empty),
    .highest_used (highest_used)
  );

endmodule

// ----- src/hst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hst_ctrl.sv -----
// Controller for the handle slot table: sequences capture, execute and
// result load, and owns the output valid flag. Depends on hst_pkg.
module hst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output hst_pkg::hst_cmd_t cmd
);

  hst_pkg::state_t state, state_next;
  logic can_load;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      hst_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = hst_pkg::S_EXEC;
        end
      end
      hst_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = hst_pkg::S_FINISH;
      end
      hst_pkg::S_FINISH: begin
        if (can_load) begin
          cmd.load    = 1'b1;
          in_ready    = 1'b1;
          cmd.capture = in_valid;
          state_next  = in_valid ? hst_pkg::S_EXEC : hst_pkg::S_IDLE;
        end
      end
      default: state_next = hst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- src/hst_dpath.sv -----
// Datapath for the handle slot table: operand capture, used bitmap, slot
// limit register, entry store and output register. Depends on hst_pkg, hst_ram.
module hst_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  hst_pkg::hst_cmd_t               cmd,
  input  logic                            cfg_wr_en,
  input  logic [hst_pkg::LIMIT_W-1:0]     cfg_wr_data,
  input  logic [1:0]                      mode,
  input  logic [hst_pkg::IDX_W-1:0]       slot_index,
  input  logic [hst_pkg::DATA_W-1:0]      entry_data,
  output logic [1:0]                      status,
  output logic [hst_pkg::IDX_W-1:0]       assigned_slot,
  output logic [hst_pkg::DATA_W-1:0]      read_data,
  output logic                            found,
  output logic                            table_empty,
  output logic [hst_pkg::IDX_W-1:0]       highest_used
);

  logic [hst_pkg::LIMIT_W-1:0]     limit;
  logic [hst_pkg::SLOTS-1:0]       used;
  logic [1:0]                      op_mode;
  logic [hst_pkg::IDX_W-1:0]       op_idx;
  logic [hst_pkg::ENTRY_WIDTH-1:0] op_data;

  hst_pkg::status_t                res_status;
  logic [hst_pkg::IDX_W-1:0]       res_assigned;
  logic                            res_hit;

  logic [hst_pkg::SLOTS-1:0]       free_mask;
  logic                            any_free;
  logic [hst_pkg::SLOT_W-1:0]      free_slot;
  logic [hst_pkg::SLOT_W-1:0]      op_slot;
  logic                            idx_hit;
  logic                            add_go;
  logic [hst_pkg::ENTRY_WIDTH-1:0] ram_rdata;
  logic [hst_pkg::SLOT_W-1:0]      top;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hst_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode <= mode;
      op_idx  <= slot_index;
      op_data <= hst_pkg::ENTRY_WIDTH'(entry_data);
    end
  end

  always_comb begin
    for (int i = 0; i < hst_pkg::SLOTS; i++) begin
      free_mask[i] = !used[i] && (i != 0) && (i < int'(limit));
    end
  end

  assign any_free  = |free_mask;
  assign free_slot = hst_pkg::lowest_set(free_mask);
  assign op_slot   = hst_pkg::SLOT_W'(op_idx);
  assign idx_hit   = (hst_pkg::LIMIT_W'(op_idx) < limit) &&
                     (int'(op_idx) < hst_pkg::SLOTS) && used[op_slot];
  assign add_go    = cmd.exec && (hst_pkg::mode_t'(op_mode) == hst_pkg::MODE_ADD) &&
                     any_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      unique case (hst_pkg::mode_t'(op_mode))
        hst_pkg::MODE_ADD: begin
          if (any_free) begin
            used[free_slot] <= 1'b1;
          end
        end
        hst_pkg::MODE_REMOVE: begin
          if (idx_hit) begin
            used[op_slot] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status   <= hst_pkg::ST_OK;
      res_assigned <= '0;
      res_hit      <= 1'b0;
      unique case (hst_pkg::mode_t'(op_mode))
        hst_pkg::MODE_ADD: begin
          if (any_free) begin
            res_assigned <= hst_pkg::IDX_W'(free_slot);
          end else begin
            res_status <= hst_pkg::ST_NO_FREE;
          end
        end
        hst_pkg::MODE_REMOVE: begin
          if (!idx_hit) begin
            res_status <= hst_pkg::ST_BAD_SLOT;
          end
        end
        hst_pkg::MODE_RETRIEVE: begin
          res_hit <= idx_hit;
        end
        default: ;
      endcase
    end
  end

  hst_ram #(
    .WIDTH(hst_pkg::ENTRY_WIDTH),
    .DEPTH(hst_pkg::SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (add_go),
    .waddr(free_slot),
    .wdata(op_data),
    .raddr(op_slot),
    .rdata(ram_rdata)
  );

  assign top = hst_pkg::highest_set(used);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status        <= res_status;
      assigned_slot <= res_assigned;
      found         <= res_hit;
      read_data     <= res_hit ? hst_pkg::DATA_W'(ram_rdata) : '0;
      highest_used  <= hst_pkg::IDX_W'(top);
      table_empty   <= (top == '0);
    end
  end

endmodule

// ----- src/hst_checker.sv -----
// Port-level checks for the handle slot table and their bind to the top.
// Depends on hst_pkg and handle_slot_table_core.
module hst_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [hst_pkg::IDX_W-1:0]   assigned_slot,
  input logic [hst_pkg::DATA_W-1:0]  read_data,
  input logic                        found,
  input logic                        table_empty,
  input logic [hst_pkg::IDX_W-1:0]   highest_used
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_data))
    else $error("result dropped or changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (table_empty == (highest_used == '0)))
    else $error("table_empty disagrees with highest_used");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != 2'(hst_pkg::ST_OK)) |-> (assigned_slot == '0) && !found)
    else $error("failed item carries a slot or a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (read_data == '0))
    else $error("read data without a hit");

  a_add_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && (assigned_slot != '0) |-> !table_empty && (highest_used >= assigned_slot))
    else $error("assigned slot above highest used");

endmodule

bind handle_slot_table_core hst_checker u_hst_checker (.*);

// ----- sim/hst_result_checker.sv -----
// Result checker for the handle slot table: watches both channels and the
// limit register, predicts every result and compares it field by field.
// Depends on hst_pkg.
module hst_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [hst_pkg::IDX_W-1:0]   slot_index,
  input  logic [hst_pkg::DATA_W-1:0]  entry_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  status,
  input  logic [hst_pkg::IDX_W-1:0]   assigned_slot,
  input  logic [hst_pkg::DATA_W-1:0]  read_data,
  input  logic                        found,
  input  logic                        table_empty,
  input  logic [hst_pkg::IDX_W-1:0]   highest_used,
  input  logic                        cfg_wr_en,
  input  logic [hst_pkg::LIMIT_W-1:0] cfg_wr_data,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hst_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] data;
    logic              hit;
    logic              empty;
    logic [IDX_W-1:0]  top;
  } slot_result_t;

  logic [LIMIT_W-1:0] slot_limit;
  logic [SLOTS-1:0]   slot_used;
  logic [DATA_W-1:0]  slot_store [SLOTS];
  logic [IDX_W-1:0]   top_slot;
  slot_result_t       expected_q [$];
  bit                 mismatch;

  function automatic slot_result_t apply_slot_op(mode_t op, logic [IDX_W-1:0] idx,
                                                 logic [DATA_W-1:0] data);
    slot_result_t r;
    int lim;
    int i;
    int m;
    bit placed;
    r.status = ST_OK;
    r.slot   = '0;
    r.data   = '0;
    r.hit    = 1'b0;
    placed   = 1'b0;
    lim = (int'(slot_limit) < SLOTS) ? int'(slot_limit) : SLOTS;
    case (op)
      MODE_ADD: begin
        r.status = ST_NO_FREE;
        for (i = 1; i < lim && !placed; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]  = 1'b1;
            slot_store[i] = data[ENTRY_WIDTH-1:0];
            r.slot   = IDX_W'(i);
            r.status = ST_OK;
            placed   = 1'b1;
            if (IDX_W'(i) > top_slot) top_slot = IDX_W'(i);
          end
        end
      end
      MODE_REMOVE: begin
        if (int'(idx) < lim && slot_used[idx]) begin
          slot_used[idx] = 1'b0;
          if (idx == top_slot) begin
            m = int'(idx);
            while (m > 0 && !slot_used[m]) m--;
            top_slot = IDX_W'(m);
          end
        end else begin
          r.status = ST_BAD_SLOT;
        end
      end
      MODE_RETRIEVE: begin
        if (int'(idx) < lim && slot_used[idx]) begin
          r.data = slot_store[idx];
          r.hit  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.empty = (top_slot == '0);
    r.top   = top_slot;
    return r;
  endfunction

  task automatic compare_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      mismatch = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      slot_limit = LIMIT_RESET;
      slot_used  = '0;
      top_slot   = '0;
      expected_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result with no item pending", $time);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          mismatch = 1'b0;
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("assigned_slot", 64'(want.slot), 64'(assigned_slot));
          compare_field("read_data", want.data, read_data);
          compare_field("found", 64'(want.hit), 64'(found));
          compare_field("table_empty", 64'(want.empty), 64'(table_empty));
          compare_field("highest_used", 64'(want.top), 64'(highest_used));
          if (mismatch) fail_count++;
        end
      end
      if (cfg_wr_en) slot_limit = cfg_wr_data;
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_slot_op(mode_t'(mode), slot_index, entry_data));
      end
      pending = expected_q.size();
    end
  end

endmodule

// ----- sim/tb_handle_slot_table_core.sv -----
// Testbench top for handle_slot_table_core: clock, reset, directed and random
// items, limit changes, idling on both sides and the final verdict.
// Depends on hst_pkg, hst_result_checker and the block itself.
module tb_handle_slot_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hst_pkg::*;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          mode;
  logic [IDX_W-1:0]    slot_index;
  logic [DATA_W-1:0]   entry_data;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [IDX_W-1:0]    assigned_slot;
  logic [DATA_W-1:0]   read_data;
  logic                found;
  logic                table_empty;
  logic [IDX_W-1:0]    highest_used;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_wr_data;
  int                  fail_count;
  int                  pending;
  bit                  steady_flow;
  logic [LIMIT_W-1:0]  cur_limit;

  handle_slot_table_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_index   (slot_index),
    .entry_data   (entry_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .assigned_slot(assigned_slot),
    .read_data    (read_data),
    .found        (found),
    .table_empty  (table_empty),
    .highest_used (highest_used),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  hst_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_index   (slot_index),
    .entry_data   (entry_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .assigned_slot(assigned_slot),
    .read_data    (read_data),
    .found        (found),
    .table_empty  (table_empty),
    .highest_used (highest_used),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item; entered and left at a falling edge.
  task automatic offer_item(mode_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    slot_index <= idx;
    entry_data <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    await_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic mode_t pick_op(int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return MODE_ADD;
    if (r < add_pct + (95 - add_pct) / 2) return MODE_REMOVE;
    if (r < 95) return MODE_RETRIEVE;
    return MODE_NOP;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot();
    int span;
    span = (cur_limit > 63) ? 63 : int'(cur_limit);
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 63));
    return IDX_W'($urandom_range(0, span));
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Receiver: random stall per item, long hold-offs at a few points.
  initial begin
    int stall;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == 150 || taken == 700 || taken == 1100) stall = 60;
      else stall = steady_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits [12];
    int add_pcts [12];
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_NOP;
    slot_index  = '0;
    entry_data  = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    steady_flow = 1'b0;
    cur_limit   = LIMIT_RESET;
    limits   = '{7'd127, 7'd64, 7'd4, 7'd2, 7'd0, 7'd1, 7'd9, 7'd40, 7'd64, 7'd3, 7'd17, 7'd127};
    add_pcts = '{70, 65, 55, 50, 40, 40, 50, 30, 45, 55, 50, 35};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_item(MODE_RETRIEVE, 6'd0, '1);
    offer_item(MODE_REMOVE, 6'd0, '0);
    offer_item(MODE_ADD, 6'd63, '1);
    offer_item(MODE_ADD, 6'd0, '0);
    offer_item(MODE_ADD, 6'd5, 64'hA5A5_A5A5_A5A5_A5A5);
    offer_item(MODE_ADD, 6'd0, 64'h5A5A_5A5A_5A5A_5A5A);
    offer_item(MODE_RETRIEVE, 6'd1, '0);
    offer_item(MODE_RETRIEVE, 6'd2, '1);
    offer_item(MODE_RETRIEVE, 6'd4, '0);
    offer_item(MODE_REMOVE, 6'd2, '0);
    offer_item(MODE_ADD, 6'd0, 64'h0123_4567_89AB_CDEF);
    offer_item(MODE_REMOVE, 6'd4, '0);
    offer_item(MODE_REMOVE, 6'd3, '0);
    offer_item(MODE_REMOVE, 6'd63, '1);
    offer_item(MODE_RETRIEVE, 6'd63, '0);
    offer_item(MODE_NOP, 6'd63, '1);
    offer_item(MODE_REMOVE, 6'd1, '0);
    offer_item(MODE_REMOVE, 6'd2, '0);
    offer_item(MODE_REMOVE, 6'd2, '0);
    offer_item(MODE_ADD, 6'd0, '1);
    write_limit(7'd2);
    offer_item(MODE_ADD, 6'd0, '1);
    offer_item(MODE_RETRIEVE, 6'd1, '0);
    offer_item(MODE_REMOVE, 6'd1, '0);
    write_limit(7'd3);
    offer_item(MODE_ADD, 6'd0, 64'hFEDC_BA98_7654_3210);
    offer_item(MODE_ADD, 6'd0, '0);

    for (int p = 0; p < 12; p++) begin
      write_limit(limits[p]);
      steady_flow = (p == 2 || p == 8);
      for (int n = 0; n < 108; n++) begin
        offer_item(pick_op(add_pcts[p]), pick_slot(), pick_data());
      end
    end
    steady_flow = 1'b0;

    await_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/hst_pkg.sv
src/hst_ram.sv
src/hst_ctrl.sv
src/hst_dpath.sv
src/handle_slot_table_core.sv
src/hst_checker.sv
sim/hst_result_checker.sv
sim/tb_handle_slot_table_core.sv
